// ----- hw/rtl/telnet_command_purge_filter_defines.svh -----
// ----------------------------------------------------------------------------
// Telnet command purge filter assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TELNET_COMMAND_PURGE_FILTER_DEFINES_SVH
`define TELNET_COMMAND_PURGE_FILTER_DEFINES_SVH

// Same-cycle implication.
`define TCPF_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcpf: same-cycle check failed");

// Next-cycle implication.
`define TCPF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcpf: next-cycle check failed");

`endif

// ----- hw/rtl/tcpf_pkg.sv -----
// ----------------------------------------------------------------------------
// Telnet command purge filter package
// Telnet codes, parser phases and the queue entry shared by the front and
// back parts of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpf_pkg;

	// Telnet command codes.
	localparam logic [7:0] TEL_IAC  = 8'hff;
	localparam logic [7:0] TEL_SE   = 8'd240;
	localparam logic [7:0] TEL_EC   = 8'd247;
	localparam logic [7:0] TEL_EL   = 8'd248;
	localparam logic [7:0] TEL_SB   = 8'd250;
	localparam logic [7:0] TEL_WILL = 8'd251;
	localparam logic [7:0] TEL_WONT = 8'd252;
	localparam logic [7:0] TEL_DO   = 8'd253;
	localparam logic [7:0] TEL_DONT = 8'd254;

	// Parser phase within the current telnet item.
	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_CMD    = 3'd1,
		PH_OPTION = 3'd2,
		PH_SBODY  = 3'd3,
		PH_SBIAC  = 3'd4
	} phase_t;

	// Results caused by one input beat: one or two output beats.
	typedef struct packed {
		logic       two;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       bvalid;
		logic       eob;
	} q_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/telnet_command_purge_filter.sv -----
// Path: a beat's results are written into the queue and then loaded into the
// output register, which holds them while out_stall is high.
// Throughput: one input beat per cycle while the queue has room; an item that
// yields two bytes (held IAC plus command) leaves the single output register as two beats.
// A queue of QUEUE_DEPTH entries between parser and output absorbs those bursts.
// Reset: asynchronous, active low; parser at item start, queue and output empty.
// ----------------------------------------------------------------------------
// Telnet command purge filter
// Drops plain bytes and EC/EL items from a pending telnet buffer and keeps
// the unsent bytes of all other IAC items.
// ----------------------------------------------------------------------------
`default_nettype none

module telnet_command_purge_filter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       already_sent,
	input  wire logic       buffer_end,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            run_last,
	output logic            end_of_buffer
);
	import tcpf_pkg::*;

	q_entry_t entry;
	q_entry_t head;
	logic     entry_push;
	logic     head_valid;
	logic     pop;
	logic     full;
	logic     accept;

	// Input beats are taken while the queue has room.
	assign in_stall = full;
	assign accept   = in_valid && !full;

	tcpf_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (in_byte),
		.already_sent (already_sent),
		.buffer_end   (buffer_end),
		.entry        (entry),
		.entry_push   (entry_push)
	);

	tcpf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (entry_push),
		.wr_entry   (entry),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	tcpf_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.run_last      (run_last),
		.end_of_buffer (end_of_buffer)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/tcpf_parse.sv -----
// ----------------------------------------------------------------------------
// Telnet command purge filter front end
// Parses the input beats into telnet items, decides which bytes are kept and
// produces one queue entry per beat that has results or ends the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpf_parse (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [7:0]         in_byte,
	input  wire logic               already_sent,
	input  wire logic               buffer_end,
	output tcpf_pkg::q_entry_t      entry,
	output logic                    entry_push
);
	import tcpf_pkg::*;

	phase_t phase_q, phase_d;
	logic   held_q, held_d;
	logic   wanted_q, wanted_d;

	logic   is_iac;
	logic   cmd_kept;
	logic   put_iac;
	logic   put_byte;

	assign is_iac   = (in_byte == TEL_IAC);
	assign cmd_kept = (in_byte != TEL_EC) && (in_byte != TEL_EL);

	// Next parser state.
	always_comb begin
		phase_d  = PH_START;
		held_d   = 1'b0;
		wanted_d = 1'b0;
		unique case (phase_q)
			PH_CMD: begin
				if (cmd_kept) begin
					case (in_byte) inside
						TEL_DO, TEL_DONT, TEL_WILL, TEL_WONT: begin
							phase_d  = PH_OPTION;
							wanted_d = 1'b1;
						end
						TEL_SB: begin
							phase_d  = PH_SBODY;
							wanted_d = 1'b1;
						end
						default: begin
							phase_d  = PH_START;
						end
					endcase
				end
			end
			PH_OPTION: begin
				phase_d = PH_START;
			end
			PH_SBODY: begin
				phase_d  = is_iac ? PH_SBIAC : PH_SBODY;
				wanted_d = wanted_q;
			end
			PH_SBIAC: begin
				if (in_byte == TEL_SE) begin
					phase_d = PH_START;
				end else begin
					phase_d  = PH_SBODY;
					wanted_d = wanted_q;
				end
			end
			default: begin
				phase_d = is_iac ? PH_CMD : PH_START;
				held_d  = is_iac && !already_sent;
			end
		endcase
		// The buffer end always returns the parser to a clean item start.
		if (buffer_end) begin
			phase_d  = PH_START;
			held_d   = 1'b0;
			wanted_d = 1'b0;
		end
	end

	// Which bytes this beat emits.
	always_comb begin
		put_iac  = 1'b0;
		put_byte = 1'b0;
		unique case (phase_q) inside
			PH_CMD: begin
				put_iac  = cmd_kept && held_q;
				put_byte = cmd_kept && !already_sent;
			end
			PH_OPTION, PH_SBODY, PH_SBIAC: begin
				put_byte = wanted_q && !already_sent;
			end
			default: begin
				// A lone IAC at the buffer end is a truncated kept item.
				put_iac = buffer_end && is_iac && !already_sent;
			end
		endcase
	end

	// Queue entry; an empty beat at the buffer end becomes an end marker.
	always_comb begin
		entry.two    = put_iac && put_byte;
		entry.byte0  = put_iac ? TEL_IAC : (put_byte ? in_byte : 8'd0);
		entry.byte1  = in_byte;
		entry.bvalid = put_iac || put_byte;
		entry.eob    = buffer_end;
		entry_push   = accept && (put_iac || put_byte || buffer_end);
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			held_q   <= 1'b0;
			wanted_q <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			held_q   <= held_d;
			wanted_q <= wanted_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tcpf_queue.sv -----
// ----------------------------------------------------------------------------
// Telnet command purge filter queue
// Short register queue that decouples the parser from the output side.
// ----------------------------------------------------------------------------
`default_nettype none
`include "telnet_command_purge_filter_defines.svh"

module tcpf_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tcpf_pkg::q_entry_t wr_entry,
	input  wire logic               pop,
	output tcpf_pkg::q_entry_t      head,
	output logic                    head_valid,
	output logic                    full
);
	import tcpf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == CNT_W'(DEPTH));

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue integrity checks.
	`TCPF_ASSERT_IMPL(a_no_overflow, clk, arst_n, push, !full)
	`TCPF_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, head_valid)
	`TCPF_ASSERT_IMPL(a_empty_ptrs, clk, arst_n, !head_valid, rd_ptr_q == wr_ptr_q)

endmodule

`default_nettype wire

// ----- hw/rtl/tcpf_emit.sv -----
// ----------------------------------------------------------------------------
// Telnet command purge filter back end
// Expands queue entries into output beats and holds them in the output
// register until the receiver takes them.
// ----------------------------------------------------------------------------
`default_nettype none
`include "telnet_command_purge_filter_defines.svh"

module tcpf_emit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tcpf_pkg::q_entry_t head,
	input  wire logic               head_valid,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              out_byte,
	output logic                    byte_valid,
	output logic                    run_last,
	output logic                    end_of_buffer
);
	import tcpf_pkg::*;

	logic       valid_q;
	logic       sub_q;
	logic [7:0] byte_q;
	logic       bvalid_q;
	logic       last_q;
	logic       eob_q;

	logic       load;
	logic       take;
	logic       last_beat;

	// The output register refills whenever it is empty or being taken.
	assign load      = !valid_q || !out_stall;
	assign take      = load && head_valid;
	assign last_beat = !head.two || sub_q;
	assign pop       = take && last_beat;

	// Output control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= head_valid;
			end
			if (take) begin
				sub_q <= head.two && !sub_q;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (take) begin
			byte_q   <= sub_q ? head.byte1 : head.byte0;
			bvalid_q <= head.bvalid;
			last_q   <= last_beat;
			eob_q    <= head.eob && last_beat;
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign byte_valid    = bvalid_q;
	assign run_last      = last_q;
	assign end_of_buffer = eob_q;

	// The second beat of a pair is only pending while its entry is at the head.
	`TCPF_ASSERT_IMPL(a_second_beat_head, clk, arst_n, sub_q, head_valid && head.two)

endmodule

`default_nettype wire
